>>> src/mi4_pkg.sv
// Shared types, widths and index helpers for the 4x4 matrix inverse unit.
// Used by mi4_ctrl, mi4_dp and the top level matrix_inverse_4x4_unit.
package mi4_pkg;

    localparam int ELEM_W   = 32;   // matrix element width
    localparam int COF_W    = 98;   // signed cofactor, exact
    localparam int DET_W    = 132;  // signed determinant, exact
    localparam int MUL_A_W  = 35;
    localparam int MUL_B_W  = 33;
    localparam int MUL_W    = MUL_A_W + MUL_B_W;
    localparam int QUO_W    = 33;   // 32 result bits plus an overflow bit
    localparam int NUM_PERM = 6;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_CLR,
        OP_T1,
        OP_T2,
        OP_T3,
        OP_T4,
        OP_T5,
        OP_T6,
        OP_D1,
        OP_D2,
        OP_D3,
        OP_D4,
        OP_ADJ_WR,
        OP_DMAG,
        OP_V1,
        OP_V2,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [3:0] rd_addr;
        logic [3:0] wr_addr;
        logic [3:0] k;
        logic       neg;
    } t_dp_cmd;

    typedef struct packed {
        logic singular;
    } t_dp_stat;

    // Column order of the six products of a 3x3 determinant and their signs.
    localparam logic [1:0] PERM_COL [NUM_PERM][3] = '{
        '{2'd0, 2'd1, 2'd2}, '{2'd1, 2'd2, 2'd0}, '{2'd2, 2'd0, 2'd1},
        '{2'd0, 2'd2, 2'd1}, '{2'd2, 2'd1, 2'd0}, '{2'd1, 2'd0, 2'd2}
    };
    localparam logic PERM_NEG [NUM_PERM] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};

    // Index among the three rows or columns left after removing one.
    function automatic logic [1:0] skip_idx(input logic [1:0] n, input logic [1:0] drop);
        skip_idx = (n < drop) ? n : n + 2'd1;
    endfunction

    // Adjugate element k = r*4+c is the cofactor of (row c, column r).
    function automatic logic [3:0] elem_addr(input logic [3:0] k, input logic [2:0] p,
                                             input logic [1:0] n);
        logic [1:0] row;
        logic [1:0] col;
        row = skip_idx(n, k[1:0]);
        col = skip_idx(PERM_COL[p][n], k[3:2]);
        elem_addr = {row, col};
    endfunction

    function automatic logic term_neg(input logic [3:0] k, input logic [2:0] p);
        term_neg = PERM_NEG[p] ^ k[0] ^ k[2];
    endfunction

endpackage

>>> src/mi4_dp.sv
// Datapath of the 4x4 matrix inverse: element store, shared multiplier,
// cofactor and determinant accumulators, adjugate store and restoring divider.
// Depends on mi4_pkg; driven by mi4_ctrl through t_dp_cmd.
module mi4_dp
    import mi4_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  t_dp_cmd             i_cmd,
    input  logic [ELEM_W-1:0]   i_element,
    output t_dp_stat            o_stat,
    output logic [ELEM_W-1:0]   o_inverse_element,
    output logic [3:0]          o_element_index,
    output logic                o_singular,
    output logic                o_saturated,
    output logic                o_last
);

    localparam int NUM_W = COF_W + 2 * FRAC_BITS;
    localparam int DSH_W = DET_W + QUO_W;
    localparam int REM_W = (NUM_W > DSH_W) ? NUM_W : DSH_W;

    logic [ELEM_W-1:0]         r_mem [16];
    logic [COF_W-1:0]          r_adj [16];
    logic signed [ELEM_W-1:0]  r_rdata;
    logic signed [COF_W-1:0]   r_adj_rd;
    logic signed [ELEM_W-1:0]  r_x;
    logic signed [ELEM_W-1:0]  r_hi;
    logic signed [MUL_W-1:0]   r_mul;
    logic signed [COF_W-1:0]   r_term;
    logic signed [COF_W-1:0]   r_acc;
    logic signed [DET_W-1:0]   r_det;
    logic [DET_W-1:0]          r_dmag;
    logic                      r_singular;
    logic [REM_W-1:0]          r_rem;
    logic [REM_W-1:0]          r_dsh;
    logic [QUO_W-1:0]          r_q;
    logic                      r_neg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic [COF_W-1:0]          num_mag;
    logic [ELEM_W-1:0]         qlo;
    logic                      q_high;
    logic [ELEM_W-1:0]         res_val;
    logic                      res_sat;

    always_comb begin
        mul_a = MUL_A_W'(r_x);
        mul_b = MUL_B_W'(r_rdata);
        case (i_cmd.op)
            OP_T3:   mul_a = $signed({3'b000, r_mul[31:0]});
            OP_T4: begin
                mul_a = MUL_A_W'(r_hi);
                mul_b = MUL_B_W'(r_x);
            end
            OP_D1:   mul_a = $signed({3'b000, r_acc[31:0]});
            OP_D2: begin
                mul_a = $signed({3'b000, r_acc[63:32]});
                mul_b = MUL_B_W'(r_x);
            end
            OP_D3: begin
                mul_a = $signed({r_acc[COF_W-1], r_acc[COF_W-1:64]});
                mul_b = MUL_B_W'(r_x);
            end
            default: ;
        endcase
    end

    assign num_mag = r_adj_rd[COF_W-1] ? COF_W'(-r_adj_rd) : COF_W'(r_adj_rd);
    assign qlo     = r_q[ELEM_W-1:0];
    assign q_high  = r_q[QUO_W-1];

    always_comb begin
        res_sat = 1'b0;
        if (r_singular) begin
            res_val = (i_cmd.k[3:2] == i_cmd.k[1:0]) ? (ELEM_W'(1) << FRAC_BITS) : '0;
        end else if (!r_neg) begin
            if (q_high || qlo[ELEM_W-1]) begin
                res_val = 32'h7FFF_FFFF;
                res_sat = 1'b1;
            end else begin
                res_val = qlo;
            end
        end else begin
            if (q_high || (qlo > 32'h8000_0000)) begin
                res_val = 32'h8000_0000;
                res_sat = 1'b1;
            end else begin
                res_val = -qlo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_mem[i_cmd.wr_addr] <= i_element;
        end
        r_rdata <= r_mem[i_cmd.rd_addr];
        if (i_cmd.op == OP_ADJ_WR) begin
            r_adj[i_cmd.k] <= r_acc;
        end
        r_adj_rd <= r_adj[i_cmd.k];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CLR: begin
                r_acc <= '0;
                r_det <= '0;
            end
            OP_T1:  r_x <= r_rdata;
            OP_T2:  r_mul <= mul_a * mul_b;
            OP_T3: begin
                r_mul <= mul_a * mul_b;
                r_hi  <= r_mul[63:32];
                r_x   <= r_rdata;
            end
            OP_T4: begin
                r_term <= COF_W'(r_mul);
                r_mul  <= mul_a * mul_b;
            end
            OP_T5:  r_term <= r_term + (COF_W'(r_mul) <<< 32);
            OP_T6:  r_acc <= i_cmd.neg ? r_acc - r_term : r_acc + r_term;
            OP_D1: begin
                r_mul <= mul_a * mul_b;
                r_x   <= r_rdata;
            end
            OP_D2: begin
                r_det <= r_det + DET_W'(r_mul);
                r_mul <= mul_a * mul_b;
            end
            OP_D3: begin
                r_det <= r_det + (DET_W'(r_mul) <<< 32);
                r_mul <= mul_a * mul_b;
            end
            OP_D4:  r_det <= r_det + (DET_W'(r_mul) <<< 64);
            OP_ADJ_WR: r_acc <= '0;
            OP_DMAG: begin
                r_dmag     <= r_det[DET_W-1] ? DET_W'(-r_det) : DET_W'(r_det);
                r_singular <= (r_det == '0);
            end
            OP_V1: begin
                r_rem <= REM_W'(num_mag) << (2 * FRAC_BITS);
                r_dsh <= REM_W'(r_dmag) << (QUO_W - 1);
                r_neg <= r_adj_rd[COF_W-1] ^ r_det[DET_W-1];
                r_q   <= '0;
            end
            OP_V2: begin
                if (r_rem >= r_dsh) begin
                    r_rem <= r_rem - r_dsh;
                    r_q   <= {r_q[QUO_W-2:0], 1'b1};
                end else begin
                    r_q   <= {r_q[QUO_W-2:0], 1'b0};
                end
                r_dsh <= r_dsh >> 1;
            end
            OP_OUT: begin
                o_inverse_element <= res_val;
                o_element_index   <= i_cmd.k;
                o_singular        <= r_singular;
                o_saturated       <= res_sat;
                o_last            <= (i_cmd.k == 4'd15);
            end
            default: ;
        endcase
    end

    assign o_stat.singular = r_singular;

endmodule

>>> src/mi4_ctrl.sv
// Sequencer of the 4x4 matrix inverse: load count, cofactor/determinant
// schedule, divider step count and output handshake. Depends on mi4_pkg.
module mi4_ctrl
    import mi4_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_LOAD, S_CLEAR, S_TERM, S_DET, S_ADJ, S_DMAG,
        S_DRD, S_DINIT, S_DSTEP, S_OUT, S_WAIT
    } t_state;

    t_state     r_state;
    logic [3:0] r_cnt;
    logic [3:0] r_k;
    logic [2:0] r_p;
    logic [2:0] r_ph;
    logic [5:0] r_step;

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_WAIT);

    always_comb begin
        o_cmd.op      = OP_IDLE;
        o_cmd.rd_addr = elem_addr(r_k, r_p, r_ph[1:0]);
        o_cmd.wr_addr = r_cnt;
        o_cmd.k       = r_k;
        o_cmd.neg     = term_neg(r_k, r_p);
        unique case (r_state)
            S_LOAD:  o_cmd.op = i_in_valid ? OP_LOAD : OP_IDLE;
            S_CLEAR: o_cmd.op = OP_CLR;
            S_TERM: begin
                case (r_ph)
                    3'd1:    o_cmd.op = OP_T1;
                    3'd2:    o_cmd.op = OP_T2;
                    3'd3:    o_cmd.op = OP_T3;
                    3'd4:    o_cmd.op = OP_T4;
                    3'd5:    o_cmd.op = OP_T5;
                    3'd6:    o_cmd.op = OP_T6;
                    default: o_cmd.op = OP_IDLE;
                endcase
            end
            S_DET: begin
                o_cmd.rd_addr = {2'b00, r_k[3:2]};
                case (r_ph)
                    3'd1:    o_cmd.op = OP_D1;
                    3'd2:    o_cmd.op = OP_D2;
                    3'd3:    o_cmd.op = OP_D3;
                    3'd4:    o_cmd.op = OP_D4;
                    default: o_cmd.op = OP_IDLE;
                endcase
            end
            S_ADJ:   o_cmd.op = OP_ADJ_WR;
            S_DMAG:  o_cmd.op = OP_DMAG;
            S_DINIT: o_cmd.op = OP_V1;
            S_DSTEP: o_cmd.op = OP_V2;
            S_OUT:   o_cmd.op = OP_OUT;
            default: o_cmd.op = OP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_k     <= '0;
            r_p     <= '0;
            r_ph    <= '0;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (i_in_valid) begin
                        r_cnt <= r_cnt + 4'd1;
                        if (r_cnt == 4'd15) begin
                            r_state <= S_CLEAR;
                        end
                    end
                end
                S_CLEAR: begin
                    r_k     <= '0;
                    r_p     <= '0;
                    r_ph    <= '0;
                    r_state <= S_TERM;
                end
                S_TERM: begin
                    if (r_ph == 3'd6) begin
                        r_ph <= '0;
                        if (r_p == 3'(NUM_PERM - 1)) begin
                            r_p     <= '0;
                            r_state <= (r_k[1:0] == 2'd0) ? S_DET : S_ADJ;
                        end else begin
                            r_p <= r_p + 3'd1;
                        end
                    end else begin
                        r_ph <= r_ph + 3'd1;
                    end
                end
                S_DET: begin
                    if (r_ph == 3'd4) begin
                        r_ph    <= '0;
                        r_state <= S_ADJ;
                    end else begin
                        r_ph <= r_ph + 3'd1;
                    end
                end
                S_ADJ: begin
                    if (r_k == 4'd15) begin
                        r_k     <= '0;
                        r_state <= S_DMAG;
                    end else begin
                        r_k     <= r_k + 4'd1;
                        r_state <= S_TERM;
                    end
                end
                S_DMAG:  r_state <= S_DRD;
                S_DRD:   r_state <= i_stat.singular ? S_OUT : S_DINIT;
                S_DINIT: begin
                    r_step  <= '0;
                    r_state <= S_DSTEP;
                end
                S_DSTEP: begin
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'(QUO_W - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT:   r_state <= S_WAIT;
                S_WAIT: begin
                    if (i_out_ready) begin
                        if (r_k == 4'd15) begin
                            r_k     <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_k     <= r_k + 4'd1;
                            r_state <= S_DRD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

endmodule

>>> src/matrix_inverse_4x4_unit.sv
// Top level of the 4x4 matrix inverse unit: stream ports, controller and datapath.
// Depends on mi4_pkg, mi4_ctrl and mi4_dp.
//
// The unit takes the sixteen elements of a 4x4 matrix in row-major order, one
// request per element, as signed fixed-point values with FRAC_BITS fraction
// bits. After the sixteenth element it forms all sixteen cofactors exactly
// and the determinant from the first row, then returns the sixteen inverse
// elements in row-major order, each the adjugate element divided by the
// determinant, truncated toward zero and clamped to the 32-bit range (the
// saturated flag marks a clamped element). An exactly zero determinant
// returns the identity matrix with the singular flag set on every element.
// One 35x33-bit multiplier is shared by all products: each cofactor term passes
// through its own phases, and each of the four first-row cofactors is then
// also multiplied into the determinant. Each inverse element then takes a read
// and a setup step, 33 steps of a one-bit-per-cycle restoring divider, the
// output register load and the handshake with the sink (a singular matrix
// skips the setup and the divider steps).
// The unit works on one matrix at a time: input is taken only while loading.
module matrix_inverse_4x4_unit
    import mi4_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] element
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] inverse_element, [35:32] element_index
    output logic [1:0]  o_m_axis_tuser,   // [0] singular, [1] saturated
    output logic        o_m_axis_tlast
);

    t_dp_cmd           cmd;
    t_dp_stat          stat;
    logic [ELEM_W-1:0] inv_elem;
    logic [3:0]        elem_idx;
    logic              singular;
    logic              saturated;

    // The controller sequences every cycle; the datapath only follows commands.
    mi4_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mi4_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_cmd             (cmd),
        .i_element         (i_s_axis_tdata),
        .o_stat            (stat),
        .o_inverse_element (inv_elem),
        .o_element_index   (elem_idx),
        .o_singular        (singular),
        .o_saturated       (saturated),
        .o_last            (o_m_axis_tlast)
    );

    // Result fields are held in the datapath output register until taken.
    assign o_m_axis_tdata = {4'b0000, elem_idx, inv_elem};
    assign o_m_axis_tuser = {saturated, singular};

endmodule

>>> verif/matrix_inverse_4x4_unit_tb.sv
// Self-checking testbench for matrix_inverse_4x4_unit: streams 4x4 matrices in and
// checks each inverse element against an exact wide-integer predictor.
// Depends on mi4_pkg and the RTL of matrix_inverse_4x4_unit.
module matrix_inverse_4x4_unit_tb;
    import mi4_pkg::*;

    localparam int FRAC = 16;
    localparam logic [31:0] ONE_Q = 32'h0001_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX = 32'h8000_0000;
    localparam int NUM_RANDOM_MATRICES = 12;

    typedef struct packed {
        logic [31:0] value;
        logic [3:0]  index;
        logic        singular;
        logic        saturated;
        logic        last;
    } t_inv_elem;

    // Directed matrices: an all-zero matrix (singular, identity returned) and
    // diag(1,-1,1,-1) in raw units, whose inverse clamps at both ends.
    localparam logic [31:0] DIR_MAT [2][16] = '{
        '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0,
          32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF}
    };
    localparam logic [31:0] DIR_EXP [2][16] = '{
        '{ONE_Q, 32'h0, 32'h0, 32'h0, 32'h0, ONE_Q, 32'h0, 32'h0,
          32'h0, 32'h0, ONE_Q, 32'h0, 32'h0, 32'h0, 32'h0, ONE_Q},
        '{POS_MAX, 32'h0, 32'h0, 32'h0, 32'h0, NEG_MAX, 32'h0, 32'h0,
          32'h0, 32'h0, POS_MAX, 32'h0, 32'h0, 32'h0, 32'h0, NEG_MAX}
    };
    localparam logic [15:0] DIR_SAT_MASK [2] = '{16'h0000, 16'h8421};
    localparam logic        DIR_SING     [2] = '{1'b1, 1'b0};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;   // [31:0] element
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;        // [31:0] inverse_element, [35:32] element_index
    logic [1:0]  o_m_axis_tuser;        // [0] singular, [1] saturated
    logic        o_m_axis_tlast;

    matrix_inverse_4x4_unit #(.FRAC_BITS(FRAC)) dut (.*);

    always #1 i_clk = ~i_clk;

    // Mirror of the matrix held by the unit and the inverse elements still owed.
    logic signed [31:0] held_matrix [16];
    int                 held_count = 0;
    t_inv_elem          pending_elems [$];
    int                 error_count = 0;
    int                 sender_idle_pct = 0;
    int                 sink_stall_pct = 0;

    // Signed 3x3 minor determinant, then the cofactor sign of (row, col).
    function automatic logic signed [199:0] cofactor_of(int row, int col);
        logic signed [199:0] m [3][3];
        logic signed [199:0] d;
        int r, c, rn, cn;
        rn = 0;
        for (r = 0; r < 4; r++) begin
            if (r != row) begin
                cn = 0;
                for (c = 0; c < 4; c++) begin
                    if (c != col) begin
                        m[rn][cn] = held_matrix[r * 4 + c];
                        cn++;
                    end
                end
                rn++;
            end
        end
        d = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
          - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
          + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
        return ((row + col) % 2 == 1) ? -d : d;
    endfunction

    // Queues the sixteen inverse elements of the matrix now held.
    function automatic void predict_inverse();
        logic signed [199:0] adj [16];
        logic signed [199:0] det;
        logic [199:0] num, dmag, quo;
        t_inv_elem e;
        logic neg;
        int k;
        det = '0;
        for (k = 0; k < 16; k++) adj[k] = cofactor_of(k % 4, k / 4);
        for (k = 0; k < 4; k++) det = det + adj[k * 4] * held_matrix[k];
        for (k = 0; k < 16; k++) begin
            e = '0;
            e.index = k[3:0];
            e.last = (k == 15);
            if (det == 0) begin
                e.singular = 1'b1;
                e.value = (k / 4 == k % 4) ? ONE_Q : 32'h0;
            end else begin
                neg = adj[k][199] ^ det[199];
                num = adj[k][199] ? -adj[k] : adj[k];
                dmag = det[199] ? -det : det;
                quo = (num << (2 * FRAC)) / dmag;
                if (!neg) begin
                    if (quo > 200'h7FFF_FFFF) begin
                        e.value = POS_MAX;
                        e.saturated = 1'b1;
                    end else begin
                        e.value = quo[31:0];
                    end
                end else begin
                    if (quo > 200'h8000_0000) begin
                        e.value = NEG_MAX;
                        e.saturated = 1'b1;
                    end else begin
                        e.value = -quo[31:0];
                    end
                end
            end
            pending_elems.push_back(e);
        end
    endfunction

    // Sends one element request, idling first at the current rate. The
    // predictor runs only when the request is accepted.
    task automatic send_element(input logic [31:0] value, input logic predict);
        logic taken;
        if ($urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < sender_idle_pct) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= value;
        do begin
            @(negedge i_clk);
            taken = o_s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        held_matrix[held_count] = value;
        held_count++;
        if (held_count == 16) begin
            held_count = 0;
            if (predict) predict_inverse();
        end
    endtask

    // Random sink stalls; the rate changes with the phase of the run.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Output values are stable at the falling edge, so a transfer that will
    // complete at the next rising edge is checked here.
    always @(negedge i_clk) begin
        t_inv_elem got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.value = o_m_axis_tdata[31:0];
            got.index = o_m_axis_tdata[35:32];
            got.singular = o_m_axis_tuser[0];
            got.saturated = o_m_axis_tuser[1];
            got.last = o_m_axis_tlast;
            if (pending_elems.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, got);
                error_count++;
            end else begin
                want = pending_elems.pop_front();
                if (got.value !== want.value) begin
                    $display("%0t: inverse_element expected %h actual %h",
                             $time, want.value, got.value);
                    error_count++;
                end
                if (got.index !== want.index) begin
                    $display("%0t: element_index expected %0d actual %0d",
                             $time, want.index, got.index);
                    error_count++;
                end
                if (got.singular !== want.singular) begin
                    $display("%0t: singular expected %b actual %b",
                             $time, want.singular, got.singular);
                    error_count++;
                end
                if (got.saturated !== want.saturated) begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, want.saturated, got.saturated);
                    error_count++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last expected %b actual %b",
                             $time, want.last, got.last);
                    error_count++;
                end
            end
        end
    end

    // Picks one element of a random matrix of the given kind.
    function automatic logic [31:0] random_element(int kind, int pos);
        logic [31:0] v;
        case (kind)
            0: v = $urandom;
            1: begin
                // Diagonally dominant, well conditioned.
                if (pos / 4 == pos % 4)
                    v = (32'h0008_0000 + $urandom_range(32'h0010_0000)) *
                        ($urandom_range(1) ? 1 : -1);
                else
                    v = $urandom_range(32'h0004_0000) - 32'h0002_0000;
            end
            2: v = $urandom_range(32'h0006_0000) - 32'h0003_0000;
            default: begin
                case ($urandom_range(5))
                    0: v = POS_MAX;
                    1: v = NEG_MAX;
                    2: v = 32'h0;
                    3: v = 32'h1;
                    4: v = 32'hFFFF_FFFF;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    initial begin
        logic [31:0] rand_mat [16];
        t_inv_elem e;
        int row, k, n, kind, dup;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: the expected results are known from the table.
        for (row = 0; row < 2; row++) begin
            for (k = 0; k < 16; k++) begin
                e.value = DIR_EXP[row][k];
                e.index = k[3:0];
                e.singular = DIR_SING[row];
                e.saturated = DIR_SAT_MASK[row][k];
                e.last = (k == 15);
                pending_elems.push_back(e);
            end
            for (k = 0; k < 16; k++) send_element(DIR_MAT[row][k], 1'b0);
        end

        // Random part: the idle rates rotate through four phases, one per matrix.
        for (n = 0; n < NUM_RANDOM_MATRICES; n++) begin
            case (n % 4)
                0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin sender_idle_pct = 58; sink_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  sink_stall_pct = 58; end
                default: begin sender_idle_pct = 33; sink_stall_pct = 33; end
            endcase
            // Once, hold the stream until every owed result has come back.
            if (n == 5) begin
                i_s_axis_tvalid <= 1'b0;
                while (pending_elems.size() != 0) @(posedge i_clk);
            end
            kind = n % 4;
            for (k = 0; k < 16; k++) rand_mat[k] = random_element(kind, k);
            if (kind == 2) begin
                // Repeat one row into another to force a zero determinant.
                row = $urandom_range(3);
                dup = (row + 1 + $urandom_range(2)) % 4;
                for (k = 0; k < 4; k++) rand_mat[dup * 4 + k] = rand_mat[row * 4 + k];
            end
            for (k = 0; k < 16; k++) send_element(rand_mat[k], 1'b1);
        end
        i_s_axis_tvalid <= 1'b0;
        sink_stall_pct = 0;

        while (pending_elems.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
